/* rtl/stip_pkg.sv */
// Shared types and constants of the string-to-integer parser.
`timescale 1ns / 1ps
`default_nettype none
package stip_pkg;

   localparam int MAX_POS     = 4095;
   localparam int POS_W       = $clog2(MAX_POS + 1);
   localparam int END_W       = 12;
   localparam int ACC_W       = 64;
   localparam int RADIX_W     = 6;
   localparam int PROD_W      = ACC_W + RADIX_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int RES_DEPTH   = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESULT_MODE = 2'd1;

   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'h3F;

   localparam logic [ACC_W-1:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [ACC_W-1:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
   localparam logic [ACC_W-1:0] S32_MAG = 64'h0000_0000_8000_0000;
   localparam logic [ACC_W-1:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;
   localparam logic [ACC_W-1:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_U64,
      MODE_S64,
      MODE_S32,
      MODE_U32
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_RANGE,
      ST_BASE
   } status_type;

   // One classified byte.
   typedef struct packed {
      logic               first;
      logic [RADIX_W-1:0] digit;
      logic               space;
      logic               plus;
      logic               minus;
      logic               zero;
      logic               xchar;
   } token_type;

   // Raw result of one string, before clamping.
   typedef struct packed {
      logic             invalid;
      logic             seen;
      logic             neg;
      logic             ovf;
      logic [ACC_W-1:0] acc;
      logic [END_W-1:0] end_pos;
   } fin_type;

endpackage
`default_nettype wire

/* rtl/stip_front.sv */
// Front end: input register that classifies each byte of the string.
`timescale 1ns / 1ps
`default_nettype none
module stip_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [7:0]          req_ch,
   input  wire logic                req_first,
   input  wire logic                q_full,
   output logic                     tok_valid,
   output stip_pkg::token_type      tok
);

   logic                valid_ff;
   logic                valid_in;
   stip_pkg::token_type tok_ff;
   stip_pkg::token_type tok_in;
   logic                load;

   function automatic logic [stip_pkg::RADIX_W-1:0] digit_of(input logic [7:0] c);
      logic [7:0] u;
      u = c & 8'hDF;
      if (c >= 8'h30 && c <= 8'h39)
         return stip_pkg::RADIX_W'(c - 8'h30);
      else if (u >= 8'h41 && u <= 8'h5A)
         return stip_pkg::RADIX_W'(u - 8'h37);
      else
         return stip_pkg::DIGIT_NONE;
   endfunction

   assign req_full  = valid_ff && q_full;
   assign load      = !valid_ff || !q_full;
   assign tok_valid = valid_ff;
   assign tok       = tok_ff;

   always_comb begin
      tok_in.first = req_first;
      tok_in.digit = digit_of(req_ch);
      tok_in.space = (req_ch == 8'h20) || (req_ch >= 8'h09 && req_ch <= 8'h0D);
      tok_in.plus  = (req_ch == 8'h2B);
      tok_in.minus = (req_ch == 8'h2D);
      tok_in.zero  = (req_ch == 8'h30);
      tok_in.xchar = (req_ch == 8'h78) || (req_ch == 8'h58);
      valid_in     = load ? req_push : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && req_push) begin
         tok_ff <= tok_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/stip_queue.sv */
// Token queue between the classifier and the parse engine.
`timescale 1ns / 1ps
`default_nettype none
module stip_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  stip_pkg::token_type      in_tok,
   output logic                     full,
   output logic                     empty,
   output stip_pkg::token_type      out_tok,
   input  wire logic                pop
);

   localparam int PTR_W = (stip_pkg::QUEUE_DEPTH > 1) ? $clog2(stip_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(stip_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(stip_pkg::QUEUE_DEPTH - 1);

   stip_pkg::token_type mem [stip_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                push;
   logic                take;

   assign full    = (count_ff == CNT_W'(stip_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign push    = in_valid && !full;
   assign take    = pop && !empty;
   assign out_tok = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (take) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !take) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (take && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_tok;
      end
   end

endmodule
`default_nettype wire

/* rtl/stip_back.sv */
// Parse engine: prefix and radix handling, digit accumulation, result capture.
`timescale 1ns / 1ps
`default_nettype none
module stip_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  stip_pkg::token_type               q_tok,
   output logic                              q_pop,
   input  wire logic [stip_pkg::RADIX_W-1:0] number_base,
   output logic                              fin_valid,
   output stip_pkg::fin_type                 fin,
   input  wire logic                         fin_take
);

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_START,
      PH_ZERO,
      PH_HEXSTART,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [stip_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic                              neg_ff, neg_in;
   logic                              ovf_ff, ovf_in;
   logic                              seen_ff, seen_in;
   logic [stip_pkg::RADIX_W-1:0]      rad_ff, rad_in;
   logic [stip_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic                              fin_valid_ff, fin_valid_in;
   stip_pkg::fin_type                 fin_ff, fin_in;
   logic                              go;

   function automatic logic [stip_pkg::END_W-1:0] to_end(input logic [stip_pkg::POS_W-1:0] p);
      logic [stip_pkg::POS_W+stip_pkg::END_W-1:0] ext;
      ext = (stip_pkg::POS_W + stip_pkg::END_W)'(p);
      return ext[stip_pkg::END_W-1:0];
   endfunction

   assign go        = !q_empty && (!fin_valid_ff || fin_take);
   assign q_pop     = go;
   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

   always_comb begin
      logic                          start;
      logic                          emit;
      logic                          invalid;
      logic                          handle;
      logic                          do_digit;
      logic [stip_pkg::POS_W-1:0]    idx;
      logic [stip_pkg::POS_W-1:0]    end_v;
      logic [stip_pkg::PROD_W-1:0]   prod;

      phase_in     = phase_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      seen_in      = seen_ff;
      rad_in       = rad_ff;
      pos_in       = pos_ff;
      fin_valid_in = fin_valid_ff && !fin_take;
      fin_in       = fin_ff;
      start        = 1'b0;
      emit         = 1'b0;
      invalid      = 1'b0;
      handle       = 1'b0;
      do_digit     = 1'b0;
      idx          = pos_ff;
      end_v        = '0;
      prod         = '0;

      if (go) begin
         start = q_tok.first || (phase_ff == PH_SKIP && pos_ff == '0);
         if (start) begin
            phase_in = PH_SKIP;
            acc_in   = '0;
            neg_in   = 1'b0;
            ovf_in   = 1'b0;
            seen_in  = 1'b0;
            pos_in   = '0;
            rad_in   = number_base;
         end
         if (start && (number_base == stip_pkg::RADIX_ONE ||
                       number_base > stip_pkg::RADIX_MAX)) begin
            emit    = 1'b1;
            invalid = 1'b1;
         end else if (phase_in != PH_DONE) begin
            idx = pos_in;
            if (pos_in < stip_pkg::POS_W'(stip_pkg::MAX_POS)) begin
               pos_in = pos_in + stip_pkg::POS_W'(1);
            end
            if (phase_in == PH_SKIP) begin
               if (!q_tok.space) begin
                  phase_in = PH_START;
                  if (q_tok.plus || q_tok.minus) begin
                     neg_in = q_tok.minus;
                  end else begin
                     handle = 1'b1;
                  end
               end
            end else begin
               handle = 1'b1;
            end
            if (handle) begin
               case (phase_in)
                  PH_START: begin
                     if (q_tok.zero && (rad_in == stip_pkg::RADIX_AUTO ||
                                        rad_in == stip_pkg::RADIX_HEX)) begin
                        phase_in = PH_ZERO;
                     end else begin
                        if (rad_in == stip_pkg::RADIX_AUTO) begin
                           rad_in = stip_pkg::RADIX_DEC;
                        end
                        phase_in = PH_DIGITS;
                        do_digit = 1'b1;
                     end
                  end
                  PH_ZERO: begin
                     if (q_tok.xchar) begin
                        rad_in   = stip_pkg::RADIX_HEX;
                        phase_in = PH_HEXSTART;
                     end else begin
                        if (rad_in == stip_pkg::RADIX_AUTO) begin
                           rad_in = stip_pkg::RADIX_OCT;
                        end
                        seen_in  = 1'b1;
                        phase_in = PH_DIGITS;
                        do_digit = 1'b1;
                     end
                  end
                  PH_HEXSTART: begin
                     // "0x" not followed by a hex digit: the subject is the "0"
                     if (q_tok.digit >= stip_pkg::RADIX_HEX) begin
                        seen_in = 1'b1;
                        acc_in  = '0;
                        emit    = 1'b1;
                        end_v   = (idx != '0) ? idx - stip_pkg::POS_W'(1) : '0;
                     end else begin
                        phase_in = PH_DIGITS;
                        do_digit = 1'b1;
                     end
                  end
                  default: begin
                     do_digit = 1'b1;
                  end
               endcase
            end
            if (do_digit) begin
               if (rad_in < stip_pkg::RADIX_MIN || q_tok.digit >= rad_in) begin
                  emit  = 1'b1;
                  end_v = idx;
               end else begin
                  prod = stip_pkg::PROD_W'(acc_in) * stip_pkg::PROD_W'(rad_in)
                       + stip_pkg::PROD_W'(q_tok.digit);
                  if (!ovf_in) begin
                     if (prod[stip_pkg::PROD_W-1:stip_pkg::ACC_W] != '0) begin
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = prod[stip_pkg::ACC_W-1:0];
                     end
                  end
                  seen_in = 1'b1;
               end
            end
         end
         if (emit) begin
            phase_in       = PH_DONE;
            fin_valid_in   = 1'b1;
            fin_in.invalid = invalid;
            fin_in.seen    = seen_in && !invalid;
            fin_in.neg     = neg_in;
            fin_in.ovf     = ovf_in;
            fin_in.acc     = acc_in;
            fin_in.end_pos = to_end(end_v);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         rad_ff       <= '0;
         pos_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         rad_ff       <= rad_in;
         pos_ff       <= pos_in;
         fin_valid_ff <= fin_valid_in;
      end
      fin_ff <= fin_in;
   end

endmodule
`default_nettype wire

/* rtl/stip_result.sv */
// Result stage: clamps per result mode and queues finished results.
`timescale 1ns / 1ps
`default_nettype none
module stip_result (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fin_valid,
   input  stip_pkg::fin_type                fin,
   output logic                             fin_take,
   input  stip_pkg::mode_type               mode,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [stip_pkg::ACC_W-1:0]       rsp_value,
   output logic [stip_pkg::END_W-1:0]       rsp_end_pos,
   output logic [1:0]                       rsp_status
);

   localparam int PTR_W = (stip_pkg::RES_DEPTH > 1) ? $clog2(stip_pkg::RES_DEPTH) : 1;
   localparam int CNT_W = $clog2(stip_pkg::RES_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(stip_pkg::RES_DEPTH - 1);

   typedef struct packed {
      logic [stip_pkg::ACC_W-1:0] value;
      logic [stip_pkg::END_W-1:0] end_pos;
      stip_pkg::status_type       status;
   } res_type;

   res_type          mem [stip_pkg::RES_DEPTH];
   res_type          res_in;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             take_out;
   logic             room;

   assign rsp_empty   = (count_ff == '0);
   assign take_out    = rsp_pop && !rsp_empty;
   assign room        = (count_ff != CNT_W'(stip_pkg::RES_DEPTH)) || take_out;
   assign fin_take    = fin_valid && room;
   assign rsp_value   = mem[rd_ptr_ff].value;
   assign rsp_end_pos = mem[rd_ptr_ff].end_pos;
   assign rsp_status  = mem[rd_ptr_ff].status;

   always_comb begin
      logic [stip_pkg::ACC_W-1:0] m;
      logic [stip_pkg::ACC_W-1:0] neg_m;
      m              = fin.acc;
      neg_m          = '0 - m;
      res_in.value   = '0;
      res_in.end_pos = fin.end_pos;
      res_in.status  = stip_pkg::ST_OK;
      if (fin.invalid) begin
         res_in.end_pos = '0;
         res_in.status  = stip_pkg::ST_BASE;
      end else if (!fin.seen) begin
         res_in.end_pos = '0;
      end else begin
         case (mode)
            stip_pkg::MODE_U64: begin
               if (fin.ovf) begin
                  res_in.value  = stip_pkg::U64_MAX;
                  res_in.status = stip_pkg::ST_RANGE;
               end else begin
                  res_in.value = fin.neg ? neg_m : m;
               end
            end
            stip_pkg::MODE_S64: begin
               if (fin.neg) begin
                  if (fin.ovf || m > stip_pkg::S64_MIN) begin
                     res_in.value  = stip_pkg::S64_MIN;
                     res_in.status = stip_pkg::ST_RANGE;
                  end else begin
                     res_in.value = neg_m;
                  end
               end else if (fin.ovf || m > stip_pkg::S64_MAX) begin
                  res_in.value  = stip_pkg::S64_MAX;
                  res_in.status = stip_pkg::ST_RANGE;
               end else begin
                  res_in.value = m;
               end
            end
            stip_pkg::MODE_S32: begin
               if (fin.neg) begin
                  if (fin.ovf || m > stip_pkg::S32_MAG) begin
                     res_in.value  = stip_pkg::S32_MIN;
                     res_in.status = stip_pkg::ST_RANGE;
                  end else begin
                     res_in.value = neg_m;
                  end
               end else if (fin.ovf || m > stip_pkg::S32_MAX) begin
                  res_in.value  = stip_pkg::S32_MAX;
                  res_in.status = stip_pkg::ST_RANGE;
               end else begin
                  res_in.value = m;
               end
            end
            stip_pkg::MODE_U32: begin
               if (fin.ovf || m > stip_pkg::U32_MAX) begin
                  res_in.value  = stip_pkg::U32_MAX;
                  res_in.status = stip_pkg::ST_RANGE;
               end else begin
                  res_in.value = (fin.neg ? neg_m : m) & stip_pkg::U32_MAX;
               end
            end
            default: begin
               res_in.value = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (fin_take) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (take_out) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (fin_take && !take_out) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (take_out && !fin_take) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (fin_take) begin
         mem[wr_ptr_ff] <= res_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/string_to_integer_parser.sv */
// Top level of the streaming string-to-integer parser.
//
// Bytes of a string enter on the req_ queue port, one per transaction,
// req_first marking the first byte of each string.  Leading white space, an
// optional sign and a radix prefix are consumed; the first non-digit byte
// (the NUL terminator included) closes the string and yields one result on
// the rsp_ queue port: value, end position and status.  Bytes after that are
// dropped until the next req_first.
// Configuration: csr_ writes set number_base (index 0) and result_mode
// (index 1); csr_ready is always high.  Write only while the block is idle.
// Throughput: one byte per cycle while req_full stays low; the accumulator
// loop does one 64x6-bit multiply-add per cycle.  A result passes the front
// register, token queue, parse engine register and result queue in turn.
// A four-entry token queue sits between classifier and parse engine, and a
// two-entry result queue feeds the output; when rsp_pop stays low the queues
// fill and req_full rises, without losing data.
// Reset clears all queues and parse state; number_base returns to 10 and
// result_mode to unsigned 64.
`timescale 1ns / 1ps
`default_nettype none
module string_to_integer_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [7:0]                        req_ch,
   input  wire logic                              req_first,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [stip_pkg::ACC_W-1:0]             rsp_value,
   output logic [stip_pkg::END_W-1:0]             rsp_end_pos,
   output logic [1:0]                             rsp_status,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [stip_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [stip_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [stip_pkg::RADIX_W-1:0] number_base_ff;
   stip_pkg::mode_type           result_mode_ff;
   logic                         tok_valid;
   stip_pkg::token_type          tok;
   logic                         q_full;
   logic                         q_empty;
   stip_pkg::token_type          q_tok;
   logic                         q_pop;
   logic                         fin_valid;
   stip_pkg::fin_type            fin;
   logic                         fin_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= stip_pkg::RADIX_DEC;
         result_mode_ff <= stip_pkg::MODE_U64;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == stip_pkg::CSR_NUMBER_BASE) begin
            number_base_ff <= csr_wdata[stip_pkg::RADIX_W-1:0];
         end else if (csr_index == stip_pkg::CSR_RESULT_MODE) begin
            result_mode_ff <= stip_pkg::mode_type'(csr_wdata[1:0]);
         end
      end
   end

   stip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_ch    (req_ch),
      .req_first (req_first),
      .q_full    (q_full),
      .tok_valid (tok_valid),
      .tok       (tok)
   );

   stip_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (tok_valid),
      .in_tok   (tok),
      .full     (q_full),
      .empty    (q_empty),
      .out_tok  (q_tok),
      .pop      (q_pop)
   );

   stip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_tok       (q_tok),
      .q_pop       (q_pop),
      .number_base (number_base_ff),
      .fin_valid   (fin_valid),
      .fin         (fin),
      .fin_take    (fin_take)
   );

   stip_result u_result (
      .clock       (clock),
      .reset       (reset),
      .fin_valid   (fin_valid),
      .fin         (fin),
      .fin_take    (fin_take),
      .mode        (result_mode_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_value   (rsp_value),
      .rsp_end_pos (rsp_end_pos),
      .rsp_status  (rsp_status)
   );

endmodule
`default_nettype wire

/* rtl/stip_checker.sv */
// Port-level checks of the parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module stip_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_full,
   input wire logic                              rsp_empty,
   input wire logic                              rsp_pop,
   input wire logic [stip_pkg::ACC_W-1:0]        rsp_value,
   input wire logic [stip_pkg::END_W-1:0]        rsp_end_pos,
   input wire logic [1:0]                        rsp_status
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_value) &&
                                    $stable(rsp_end_pos) && $stable(rsp_status)))
      else $error("stalled result changed");

   a_base_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == stip_pkg::ST_BASE) |->
         (rsp_value == '0 && rsp_end_pos == '0))
      else $error("invalid base result carries data");

   a_range_has_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == stip_pkg::ST_RANGE) |-> (rsp_end_pos != '0))
      else $error("clamped result without consumed digits");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status == stip_pkg::ST_OK || rsp_status == stip_pkg::ST_RANGE ||
                      rsp_status == stip_pkg::ST_BASE))
      else $error("undefined status code");

endmodule

bind string_to_integer_parser stip_checker u_checker (.*);
`default_nettype wire
